FILE: design/srle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg : shared types and constants for the SGI RLE row decoder
// Transaction payloads, decoder phase and word codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int GROUP_LANES_DEF = 8;
  localparam int MAX_LANES       = 8;
  localparam int SAMPLE_W        = 16;
  localparam int FILL_W          = 4;
  localparam int RUN_W           = 7;
  localparam int POS_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BPS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;

  // bytes_per_sample code that selects 16-bit samples
  localparam logic [1:0] BPS_WIDE = 2'd2;

  typedef enum logic [1:0] {
    ST_SAMPLES = 2'd0,
    ST_END     = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // what the current byte turns out to be
  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_END     = 3'd1,
    K_ERR     = 3'd2,
    K_RUN     = 3'd3,
    K_REPEAT  = 3'd4,
    K_LITERAL = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic [FILL_W-1:0]   sample_count;
    status_t             status;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    decode;
    logic    fill;
    logic    emit;
    status_t emit_status;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    kind_t  kind;
    logic   lit_full;
    logic   chunk_full;
    logic   out_free;
    logic   last;
    phase_t phase;
  } stat_t;

endpackage

FILE: design/srle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_ctrl : sequencing controller of the RLE row decoder
// Takes one byte at a time, steps the datapath through decode, repeat fill,
// group emission and end-of-row handling.
// ----------------------------------------------------------------------------
module srle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  srle_pkg::stat_t st,
  output srle_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IN,
    S_DECODE,
    S_FILL,
    S_EMIT,
    S_LAST
  } state_t;

  state_t            state_r, state_nxt;
  srle_pkg::status_t status_r, status_nxt;

  // byte intake only while waiting for input
  assign in_stall = (state_r != S_IN);

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    cmd             = '0;
    cmd.emit_status = status_r;
    case (state_r)
      S_IN: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (st.kind)
          srle_pkg::K_END: begin
            status_nxt = srle_pkg::ST_END;
            state_nxt  = S_EMIT;
          end
          srle_pkg::K_ERR: begin
            status_nxt = srle_pkg::ST_ERROR;
            state_nxt  = S_EMIT;
          end
          srle_pkg::K_REPEAT: begin
            state_nxt = S_FILL;
          end
          srle_pkg::K_LITERAL: begin
            if (st.lit_full) begin
              status_nxt = srle_pkg::ST_SAMPLES;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_LAST;
            end
          end
          default: begin
            state_nxt = S_LAST;
          end
        endcase
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.chunk_full) begin
          status_nxt = srle_pkg::ST_SAMPLES;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (status_r == srle_pkg::ST_SAMPLES && st.phase == srle_pkg::PH_REPEAT) begin
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (!st.last) begin
          state_nxt = S_IN;
        end else if (st.phase == srle_pkg::PH_DONE) begin
          cmd.clear = 1'b1;
          state_nxt = S_IN;
        end else begin
          status_nxt = srle_pkg::ST_ERROR;
          state_nxt  = S_EMIT;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  // state and registered status code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IN;
      status_r <= srle_pkg::ST_SAMPLES;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // repeat fill only runs inside a repeat run
  a_fill_in_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> st.phase == srle_pkg::PH_REPEAT)
    else $error("repeat fill outside a repeat run");

endmodule

FILE: design/srle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_dp : datapath of the RLE row decoder
// Holds configuration, row state, the sample group buffer and the output
// register; acts on commands from the controller and reports status.
// ----------------------------------------------------------------------------
module srle_dp #(
  parameter int GROUP_LANES = srle_pkg::GROUP_LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srle_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output srle_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  input  logic [srle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  srle_pkg::cmd_t                      cmd,
  output srle_pkg::stat_t                     st
);

  localparam int FW = srle_pkg::FILL_W;
  localparam int SW = srle_pkg::SAMPLE_W;
  localparam int RW = srle_pkg::RUN_W;
  localparam int PW = srle_pkg::POS_W;
  localparam logic [FW-1:0] LANES_F = FW'(GROUP_LANES);

  // configuration
  logic [1:0]    bps_r, bps_nxt;
  logic [PW-1:0] row_width_r, row_width_nxt;

  // row state
  srle_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          parity_r, parity_nxt;
  logic [RW-1:0] run_r, run_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [7:0]          byte_r;
  logic                last_r;
  logic [SW-1:0]       rep_r;
  logic [SW-1:0]       grp_r [GROUP_LANES];
  srle_pkg::out_item_t out_r;

  logic          wide;
  logic          have_word;
  logic [SW-1:0] word;
  logic [RW-1:0] count;
  logic [PW:0]   pos_sum;
  logic          overflow;
  srle_pkg::kind_t kind;
  logic [FW-1:0] room;
  logic [FW-1:0] chunk;
  logic          chunk_full;
  logic [FW-1:0] fill_end;
  logic [SW-1:0] lane_out [srle_pkg::MAX_LANES];

  // word assembly from the latched byte
  assign wide      = (bps_r == srle_pkg::BPS_WIDE);
  assign have_word = (phase_r != srle_pkg::PH_DONE) && !(wide && !parity_r);
  assign word      = wide ? {hold_r, byte_r} : {8'h00, byte_r};
  assign count     = word[RW-1:0];
  assign pos_sum   = {1'b0, pos_r} + (PW+1)'(count);
  assign overflow  = pos_sum > {1'b0, row_width_r};

  // classify the byte
  always_comb begin
    kind = srle_pkg::K_NONE;
    if (have_word) begin
      case (phase_r)
        srle_pkg::PH_CTRL: begin
          if (count == '0) begin
            kind = srle_pkg::K_END;
          end else if (overflow) begin
            kind = srle_pkg::K_ERR;
          end else begin
            kind = srle_pkg::K_RUN;
          end
        end
        srle_pkg::PH_REPEAT:  kind = srle_pkg::K_REPEAT;
        srle_pkg::PH_LITERAL: kind = srle_pkg::K_LITERAL;
        default:              kind = srle_pkg::K_NONE;
      endcase
    end
  end

  // repeat chunk: as many lanes as the run and the group allow
  assign room       = LANES_F - fill_r;
  assign chunk_full = (run_r >= RW'(room));
  assign chunk      = chunk_full ? room : run_r[FW-1:0];
  assign fill_end   = fill_r + chunk;

  assign st.kind       = kind;
  assign st.lit_full   = ((fill_r + FW'(1)) == LANES_F);
  assign st.chunk_full = chunk_full;
  assign st.out_free   = !out_valid_r || !out_stall;
  assign st.last       = last_r;
  assign st.phase      = phase_r;

  // group lanes padded to the output width, unused lanes zero
  for (genvar i = 0; i < srle_pkg::MAX_LANES; i++) begin : g_lane
    if (i < GROUP_LANES) begin : g_used
      assign lane_out[i] = (FW'(i) < fill_r) ? grp_r[i] : '0;
    end else begin : g_pad
      assign lane_out[i] = '0;
    end
  end

  // control state next values
  always_comb begin
    bps_nxt       = bps_r;
    row_width_nxt = row_width_r;
    phase_nxt     = phase_r;
    hold_nxt      = hold_r;
    parity_nxt    = parity_r;
    run_nxt       = run_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid) begin
      case (cfg_index)
        srle_pkg::CFG_BPS:       bps_nxt       = cfg_data[1:0];
        srle_pkg::CFG_ROW_WIDTH: row_width_nxt = cfg_data[PW-1:0];
        default: ;
      endcase
    end

    if (cmd.decode) begin
      if (!wide) begin
        parity_nxt = 1'b0;
      end
      if (phase_r != srle_pkg::PH_DONE) begin
        if (wide && !parity_r) begin
          hold_nxt   = byte_r;
          parity_nxt = 1'b1;
        end else begin
          parity_nxt = 1'b0;
        end
      end
      case (kind)
        srle_pkg::K_END, srle_pkg::K_ERR: begin
          phase_nxt = srle_pkg::PH_DONE;
        end
        srle_pkg::K_RUN: begin
          run_nxt   = count;
          phase_nxt = word[7] ? srle_pkg::PH_LITERAL : srle_pkg::PH_REPEAT;
        end
        srle_pkg::K_LITERAL: begin
          fill_nxt = fill_r + FW'(1);
          pos_nxt  = pos_r + PW'(1);
          run_nxt  = run_r - RW'(1);
          if (run_r == RW'(1)) begin
            phase_nxt = srle_pkg::PH_CTRL;
          end
        end
        default: ;
      endcase
    end

    if (cmd.fill) begin
      fill_nxt = fill_end;
      pos_nxt  = pos_r + PW'(chunk);
      run_nxt  = run_r - RW'(chunk);
      if (run_r == RW'(chunk)) begin
        phase_nxt = srle_pkg::PH_CTRL;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      fill_nxt      = '0;
      if (cmd.emit_status != srle_pkg::ST_SAMPLES) begin
        phase_nxt = srle_pkg::PH_DONE;
      end
    end

    if (cmd.clear) begin
      phase_nxt  = srle_pkg::PH_CTRL;
      hold_nxt   = '0;
      parity_nxt = 1'b0;
      run_nxt    = '0;
      pos_nxt    = '0;
      fill_nxt   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r       <= 2'd1;
      row_width_r <= PW'(1);
      phase_r     <= srle_pkg::PH_CTRL;
      hold_r      <= '0;
      parity_r    <= 1'b0;
      run_r       <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bps_r       <= bps_nxt;
      row_width_r <= row_width_nxt;
      phase_r     <= phase_nxt;
      hold_r      <= hold_nxt;
      parity_r    <= parity_nxt;
      run_r       <= run_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // byte latch, repeat value and group buffer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_item.data_byte;
      last_r <= in_item.last_byte;
    end
    if (cmd.decode && kind == srle_pkg::K_REPEAT) begin
      rep_r <= word;
    end
    for (int i = 0; i < GROUP_LANES; i++) begin
      if (cmd.decode && kind == srle_pkg::K_LITERAL && fill_r == FW'(i)) begin
        grp_r[i] <= word;
      end
      if (cmd.fill && FW'(i) >= fill_r && FW'(i) < fill_end) begin
        grp_r[i] <= rep_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.sample_0     <= lane_out[0];
      out_r.sample_1     <= lane_out[1];
      out_r.sample_2     <= lane_out[2];
      out_r.sample_3     <= lane_out[3];
      out_r.sample_4     <= lane_out[4];
      out_r.sample_5     <= lane_out[5];
      out_r.sample_6     <= lane_out[6];
      out_r.sample_7     <= lane_out[7];
      out_r.sample_count <= fill_r;
      out_r.status       <= cmd.emit_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // group fill never passes the lane count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LANES_F)
    else $error("group fill beyond lane count");

  // a plain sample group only goes out when full
  a_full_group: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.emit_status == srle_pkg::ST_SAMPLES |-> fill_r == LANES_F)
    else $error("partial group sent without row status");

  // a pending transaction is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.emit)
    else $error("output register overwritten while stalled");

endmodule

FILE: design/sgi_rle_row_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_rle_row_decoder : SGI RLE channel row decoder
// Expands one row of compressed bytes into groups of raw samples with a
// row status.
// ----------------------------------------------------------------------------
// One compressed byte is taken per input transaction and passes through the
// controller's intake, decode and end-of-row check states. Each group sent
// adds a pass through the emit state, and a repeat run adds a buffer fill
// step for every group it spans, with input held all the while. Results wait
// in an output register, so a stalled result only holds the decoder when the
// next group is ready to go. bytes_per_sample (index 0, 2 means 16-bit
// big-endian) and row_width (index 1) are to be written by the user through
// the cfg port between rows; the block itself does not enforce this. It comes
// out of reset ready to take bytes, with no clearing pass.
module sgi_rle_row_decoder #(
  parameter int GROUP_LANES = srle_pkg::GROUP_LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  srle_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output srle_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srle_pkg::CFG_DATA_W-1:0] cfg_data
);

  srle_pkg::cmd_t  cmd;
  srle_pkg::stat_t st;

  // configuration writes always taken
  assign cfg_ready = 1'b1;

  srle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  srle_dp #(
    .GROUP_LANES (GROUP_LANES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: tb/tb_sgi_rle_row_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sgi_rle_row_decoder : self-checking bench for the SGI RLE row decoder
// Feeds compressed rows byte by byte under random input gaps and output
// stalls. A local decoder model predicts every sample group, and each group
// the block sends is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sgi_rle_row_decoder;

  localparam int LANES         = srle_pkg::GROUP_LANES_DEF;
  localparam int SW            = srle_pkg::SAMPLE_W;
  localparam int ITEM_W        = $bits(srle_pkg::out_item_t);
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BYTES  = 450;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  srle_pkg::in_item_t              in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  srle_pkg::out_item_t             out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [srle_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [srle_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  sgi_rle_row_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder model state and its copy of the registers
  logic [1:0]          model_bps   = 2'd1;
  logic [15:0]         model_width = 16'd1;
  srle_pkg::phase_t    row_phase   = srle_pkg::PH_CTRL;
  logic [7:0]          held_hi     = '0;
  logic                half_word   = 1'b0;
  logic [6:0]          run_left    = '0;
  logic [15:0]         row_pos     = '0;
  logic [15:0]         lane_buf [LANES];
  int unsigned         lane_fill   = 0;
  srle_pkg::out_item_t pending_groups [$];

  // stimulus side
  logic [1:0]  cur_bps    = 2'd1;
  logic [15:0] cur_width  = 16'd1;
  logic [7:0]  row_q [$];
  bit          calm       = 1'b0;
  int          sent_bytes = 0;
  int          mismatches = 0;
  int          cycles     = 0;

  // one lane of a flattened group
  function automatic logic [SW-1:0] lane_of(input logic [ITEM_W-1:0] v, input int i);
    return v[ITEM_W-1-SW*i -: SW];
  endfunction

  // close the current group with the given status
  function automatic void emit_group(input srle_pkg::status_t st);
    logic [ITEM_W-1:0] v;
    srle_pkg::out_item_t grp;
    v = '0;
    for (int i = 0; i < LANES; i++)
      if (i < lane_fill) v[ITEM_W-1-SW*i -: SW] = lane_buf[i];
    grp = srle_pkg::out_item_t'(v);
    grp.sample_count = 4'(lane_fill);
    grp.status = st;
    pending_groups.push_back(grp);
    lane_fill = 0;
  endfunction

  function automatic void add_sample(input logic [15:0] s);
    lane_buf[lane_fill] = s;
    lane_fill++;
    if (lane_fill >= LANES) emit_group(srle_pkg::ST_SAMPLES);
  endfunction

  // one compressed byte through the model
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic wide;
    logic got_word;
    logic [15:0] word;
    logic [6:0] cnt;
    wide = (model_bps == srle_pkg::BPS_WIDE);
    got_word = 1'b0;
    word = '0;
    if (!wide) half_word = 1'b0;
    if (row_phase != srle_pkg::PH_DONE) begin
      if (wide && !half_word) begin
        held_hi = b;
        half_word = 1'b1;
      end else begin
        word = wide ? {held_hi, b} : {8'h00, b};
        half_word = 1'b0;
        got_word = 1'b1;
      end
    end
    if (got_word) begin
      case (row_phase)
        srle_pkg::PH_CTRL: begin
          cnt = word[6:0];
          if (cnt == 0) begin
            emit_group(srle_pkg::ST_END);
            row_phase = srle_pkg::PH_DONE;
          end else if (int'(row_pos) + int'(cnt) > int'(model_width)) begin
            emit_group(srle_pkg::ST_ERROR);
            row_phase = srle_pkg::PH_DONE;
          end else begin
            run_left = cnt;
            row_phase = word[7] ? srle_pkg::PH_LITERAL : srle_pkg::PH_REPEAT;
          end
        end
        srle_pkg::PH_REPEAT: begin
          for (int i = 0; i < run_left; i++) add_sample(word);
          row_pos = row_pos + 16'(run_left);
          run_left = '0;
          row_phase = srle_pkg::PH_CTRL;
        end
        default: begin
          add_sample(word);
          row_pos = row_pos + 16'd1;
          run_left = run_left - 7'd1;
          if (run_left == 0) row_phase = srle_pkg::PH_CTRL;
        end
      endcase
    end
    // any byte marked last starts a fresh row
    if (last) begin
      if (row_phase != srle_pkg::PH_DONE) emit_group(srle_pkg::ST_ERROR);
      row_phase = srle_pkg::PH_CTRL;
      held_hi = '0;
      half_word = 1'b0;
      run_left = '0;
      row_pos = '0;
      lane_fill = 0;
    end
  endfunction

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // compare one received group with the oldest prediction
  function automatic void check_group(input srle_pkg::out_item_t got);
    srle_pkg::out_item_t want;
    logic [ITEM_W-1:0] got_v;
    logic [ITEM_W-1:0] want_v;
    if (pending_groups.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("group received with none expected: 0x%0h", got);
      return;
    end
    want = pending_groups.pop_front();
    got_v = got;
    want_v = want;
    for (int i = 0; i < LANES; i++)
      if (lane_of(got_v, i) !== lane_of(want_v, i))
        flag_mismatch($sformatf("sample_%0d", i), lane_of(want_v, i), lane_of(got_v, i));
    if (got.sample_count !== want.sample_count)
      flag_mismatch("sample_count", want.sample_count, got.sample_count);
    if (got.status !== want.status)
      flag_mismatch("status", want.status, got.status);
  endfunction

  // transaction monitor: register writes, accepted bytes, accepted groups
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srle_pkg::CFG_BPS:       model_bps = cfg_data[1:0];
          srle_pkg::CFG_ROW_WIDTH: model_width = cfg_data;
          default:                 ;
        endcase
      end
      if (in_valid && !in_stall) begin
        sent_bytes++;
        decode_byte(in_item.data_byte, in_item.last_byte);
      end
      if (out_valid && !out_stall) check_group(out_item);
    end
  end

  // result side back-pressure
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 20);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one byte, held until accepted; valid stays high for the next byte
  task automatic send_byte(input logic [7:0] b, input logic lst);
    srle_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = lst;
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_row();
    for (int i = 0; i < row_q.size(); i++) send_byte(row_q[i], i == row_q.size() - 1);
  endtask

  // wait until every predicted group is out and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] bps, input logic [15:0] width);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= srle_pkg::CFG_BPS;
    cfg_data  <= {14'($urandom), bps};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= srle_pkg::CFG_ROW_WIDTH;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_bps = bps;
    cur_width = width;
  endtask

  // row building: one sample or control word in the current width
  function automatic void add_word(input logic [15:0] w);
    if (cur_bps == srle_pkg::BPS_WIDE) row_q.push_back(w[15:8]);
    row_q.push_back(w[7:0]);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed runs that stay inside the row; optionally closed with a terminator
  function automatic int unsigned build_runs(input bit close, input int max_runs);
    int unsigned pos;
    int unsigned room;
    int unsigned cap;
    int unsigned cnt;
    int runs;
    bit lit;
    row_q.delete();
    pos = 0;
    runs = 0;
    while (pos < cur_width && runs < max_runs) begin
      room = cur_width - pos;
      cap = ($urandom_range(3) == 0) ? 127 : 12;
      if (cap > room) cap = room;
      cnt = $urandom_range(cap, 1);
      lit = $urandom_range(1);
      add_word({8'($urandom), lit, 7'(cnt)});
      if (lit) repeat (cnt) add_word(rand_sample());
      else add_word(rand_sample());
      pos += cnt;
      runs++;
    end
    if (close) begin
      add_word({8'($urandom), 1'($urandom), 7'd0});
      repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) row_q.push_back(8'($urandom));
    end
    return cur_width - pos;
  endfunction

  // reset values of the registers: 8-bit samples, one pixel per row
  task automatic test_reset_values();
    row_q = {8'h01, 8'hFF, 8'h00};
    send_row();
  endtask

  // literal run filling a group exactly, empty terminator, bytes after the end
  task automatic test_full_group();
    set_config(2'd1, 16'd16);
    row_q = {8'h88, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h00, 8'hFF};
    send_row();
  endtask

  // 16-bit samples, ignored control high byte, repeat spilling 16 groups in one step
  task automatic test_wide_repeat();
    set_config(srle_pkg::BPS_WIDE, 16'hFFFF);
    row_q = {8'h00, 8'h07, 8'h12, 8'h34, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h80};
    send_row();
  endtask

  // run passing the row width, then a zero-width row
  task automatic test_run_past_width();
    set_config(2'd1, 16'd3);
    row_q = {8'h02, 8'hA5, 8'h82, 8'h01, 8'h00};
    send_row();
    set_config(2'd3, 16'd0);
    send_byte(8'h01, 1'b1);
  endtask

  // data ends inside a literal run, and after half of a 16-bit word
  task automatic test_early_end();
    set_config(2'd1, 16'd8);
    row_q = {8'h85, 8'h10, 8'h20, 8'h30};
    send_row();
    set_config(srle_pkg::BPS_WIDE, 16'd8);
    send_byte(8'h00, 1'b1);
  endtask

  // sample width drops to 8 bits with a high byte held
  task automatic test_width_change_in_row();
    set_config(srle_pkg::BPS_WIDE, 16'd4);
    send_byte(8'h12, 1'b0);
    set_config(2'd1, 16'd4);
    row_q = {8'h02, 8'h66, 8'h00};
    send_row();
  endtask

  // random settings and rows: mostly well-formed, some cut short, overrun or noise
  task automatic test_random_rows();
    int start;
    int unsigned r;
    int unsigned room;
    logic [1:0] bps;
    logic [15:0] width;
    start = sent_bytes;
    while (sent_bytes - start < RANDOM_BYTES) begin
      // an early stretch with no gaps and no stalls
      calm = (sent_bytes - start < 100);
      r = $urandom_range(99);
      if (r < 5) bps = 2'd0;
      else if (r < 10) bps = 2'd3;
      else if (r < 55) bps = 2'd1;
      else bps = srle_pkg::BPS_WIDE;
      r = $urandom_range(99);
      if (r < 4) width = 16'd0;
      else if (r < 14) width = 16'hFFFF;
      else if (r < 20) width = 16'($urandom_range(130, 120));
      else width = 16'($urandom_range(48, 1));
      set_config(bps, width);
      repeat ($urandom_range(6, 2)) begin
        if (sent_bytes - start >= RANDOM_BYTES) break;
        r = $urandom_range(99);
        if (r < 60) begin
          room = build_runs(1'b1, $urandom_range(6, 1));
        end else if (r < 75) begin
          room = build_runs(1'b1, $urandom_range(6, 1));
          row_q = row_q[0:$urandom_range(row_q.size(), 1) - 1];
        end else if (r < 88) begin
          room = build_runs(1'b0, $urandom_range(4, 0));
          if (room < 127)
            add_word({8'($urandom), 1'($urandom), 7'($urandom_range(127, room + 1))});
          else
            add_word({8'($urandom), 1'($urandom), 7'($urandom_range(127, 1))});
          repeat ($urandom_range(2)) row_q.push_back(8'($urandom));
        end else begin
          row_q.delete();
          repeat ($urandom_range(16, 1)) row_q.push_back(8'($urandom));
        end
        send_row();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_full_group();
    test_wide_repeat();
    test_run_past_width();
    test_early_end();
    test_width_change_in_row();
    test_random_rows();
    drain();
    if (mismatches == 0 && pending_groups.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
